FILE: src/lprl_pkg.sv
package lprl_pkg;

    localparam int LPRL_ENTRIES   = 16;
    localparam int LPRL_NUM_PORTS = 4;

    localparam int ADDR_W = 32;
    localparam int IDX_W  = 4;
    localparam int PORT_W = 2;
    localparam int LEN_W  = 6;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // One item as it moves down the cell row: the command with its payload,
    // plus the best match found so far for a lookup.
    typedef struct packed {
        logic              vld;
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
        logic              slot_vld;
        logic [LEN_W-1:0]  mask_len;
        logic [ADDR_W-1:0] addr;
        logic              found;
        logic [LEN_W-1:0]  best_len;
        logic [ADDR_W-1:0] best_gw;
        logic [PORT_W-1:0] best_port;
    } t_item;

    // Ones count of a 32-bit mask: per-byte counts, then a four-way add.
    function automatic logic [LEN_W-1:0] count_ones(input logic [ADDR_W-1:0] v);
        logic [3:0]       byte_cnt [4];
        logic [LEN_W-1:0] total;
        for (int b = 0; b < 4; b++) begin
            byte_cnt[b] = '0;
            for (int k = 0; k < 8; k++) begin
                byte_cnt[b] = byte_cnt[b] + {3'b000, v[b*8+k]};
            end
        end
        total = {2'b00, byte_cnt[0]} + {2'b00, byte_cnt[1]}
              + {2'b00, byte_cnt[2]} + {2'b00, byte_cnt[3]};
        return total;
    endfunction

endpackage

FILE: src/longest_prefix_route_lookup_core.sv
// IPv4 longest-prefix route table, one slot per cell in a row of ENTRIES cells.
// Input: an item is taken when start is high and busy is low. i_command selects
// a slot write (slot_* fields) or a lookup (i_lookup_address).
// Writes give no result. Each lookup gives one result, shown for exactly one
// cycle with o_done high: o_hit, o_next_hop, o_out_port, o_prefix_length.
// Every item walks the row one cell per cycle; the cell holding slot k compares
// against a lookup as it passes, or stores a write aimed at slot k. Items stay
// in order, so a lookup sees exactly the writes taken before it.
// o_done rises once a lookup has passed the registers of all ENTRIES cells.
// Throughput: one item (write or lookup) per cycle while busy is low, set by the
// one-cell step of the row; busy is high during reset and in the cycle after it.
// Reset (synchronous, i_rst_n low) clears all slot valid bits and drops every
// item in flight. The receiver cannot stall; results must be taken when shown.
// On a miss all result fields read zero. Ties in length go to the lowest slot.
module longest_prefix_route_lookup_core
    import lprl_pkg::*;
#(
    parameter int ENTRIES   = LPRL_ENTRIES,
    parameter int NUM_PORTS = LPRL_NUM_PORTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_command,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic [ADDR_W-1:0] i_slot_prefix,
    input  logic [ADDR_W-1:0] i_slot_mask,
    input  logic [ADDR_W-1:0] i_slot_gateway,
    input  logic [PORT_W-1:0] i_slot_port,
    input  logic              i_slot_valid,
    input  logic [ADDR_W-1:0] i_lookup_address,
    output logic              o_done,
    output logic              o_hit,
    output logic [ADDR_W-1:0] o_next_hop,
    output logic [PORT_W-1:0] o_out_port,
    output logic [LEN_W-1:0]  o_prefix_length
);

    logic  r_busy;
    logic  w_accept;
    t_item w_chain [ENTRIES+1];
    t_item w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    always_comb begin
        w_chain[0]          = '0;
        w_chain[0].vld      = w_accept;
        w_chain[0].cmd      = i_command;
        w_chain[0].idx      = i_slot_index;
        w_chain[0].prefix   = i_slot_prefix;
        w_chain[0].mask     = i_slot_mask;
        w_chain[0].gateway  = i_slot_gateway;
        w_chain[0].port     = i_slot_port;
        if (32'(i_slot_port) >= 32'(NUM_PORTS)) begin
            w_chain[0].port = PORT_W'(NUM_PORTS - 1);
        end
        w_chain[0].slot_vld = i_slot_valid;
        w_chain[0].mask_len = count_ones(i_slot_mask);
        w_chain[0].addr     = i_lookup_address;
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lprl_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_item (w_chain[g]),
            .o_item (w_chain[g+1])
        );
    end

    assign w_last = w_chain[ENTRIES];

    always_comb begin
        o_done          = w_last.vld && (w_last.cmd == CMD_LOOKUP);
        o_hit           = o_done && w_last.found;
        o_next_hop      = '0;
        o_out_port      = '0;
        o_prefix_length = '0;
        if (w_last.found) begin
            o_next_hop      = (w_last.best_gw != '0) ? w_last.best_gw : w_last.addr;
            o_out_port      = w_last.best_port;
            o_prefix_length = w_last.best_len;
        end
    end

    a_done_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_accept && (i_command == CMD_LOOKUP), ENTRIES))
        else $error("result without a lookup taken ENTRIES cycles earlier");

    a_lookup_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_command == CMD_LOOKUP)) |-> ##ENTRIES o_done)
        else $error("lookup taken but no result after ENTRIES cycles");

    a_hit_fields_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> ((o_prefix_length <= LEN_W'(32))
                   && (32'(o_out_port) < 32'(NUM_PORTS))))
        else $error("hit with out-of-range length or port");

endmodule

FILE: src/lprl_cell.sv
module lprl_cell
    import lprl_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_item o_item
);

    logic              r_valid;
    logic [ADDR_W-1:0] r_prefix;
    logic [ADDR_W-1:0] r_mask;
    logic [ADDR_W-1:0] r_gw;
    logic [PORT_W-1:0] r_port;
    logic [LEN_W-1:0]  r_len;

    logic  r_vld;
    t_item r_item;
    t_item n_item;

    logic w_wr;
    logic w_match;
    logic w_take;

    always_comb begin
        w_wr    = i_item.vld && (i_item.cmd == CMD_WRITE)
                  && (32'(i_item.idx) == 32'(CELL_ID));
        w_match = r_valid && (((i_item.addr ^ r_prefix) & r_mask) == '0);
        // strictly longer only: an equal length leaves the lower slot in place
        w_take  = (i_item.cmd == CMD_LOOKUP) && w_match
                  && (!i_item.found || (r_len > i_item.best_len));
        n_item = i_item;
        if (w_take) begin
            n_item.found     = 1'b1;
            n_item.best_len  = r_len;
            n_item.best_gw   = r_gw;
            n_item.best_port = r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_item.vld;
            if (w_wr) begin
                r_valid <= i_item.slot_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        if (w_wr) begin
            r_prefix <= i_item.prefix;
            r_mask   <= i_item.mask;
            r_gw     <= i_item.gateway;
            r_port   <= i_item.port;
            r_len    <= i_item.mask_len;
        end
    end

    always_comb begin
        o_item     = r_item;
        o_item.vld = r_vld;
    end

endmodule
